// ===== rtl/core/geo_location_spec_parser_assert.svh =====
// Assertion macros used by the parser controller RTL
`ifndef GEO_LOCATION_SPEC_PARSER_ASSERT_SVH
`define GEO_LOCATION_SPEC_PARSER_ASSERT_SVH

// check that cons holds in the same cycle whenever ante holds
`define GLSP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check that cons holds in the cycle after ante holds
`define GLSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/glsp_pkg.sv =====
// ----------------------------------------------------------------------------
// glsp_pkg
// Phase codes, error codes and the command and status types shared by the
// location spec parser controller and datapath.
// ----------------------------------------------------------------------------
package glsp_pkg;

  localparam logic [4:0] PH_TOP    = 5'd0;
  localparam logic [4:0] PH_CDIM   = 5'd1;
  localparam logic [4:0] PH_CCOMMA = 5'd2;
  localparam logic [4:0] PH_MINX   = 5'd3;
  localparam logic [4:0] PH_MINY   = 5'd4;
  localparam logic [4:0] PH_MAXX   = 5'd5;
  localparam logic [4:0] PH_MAXY   = 5'd6;
  localparam logic [4:0] PH_PDIM   = 5'd7;
  localparam logic [4:0] PH_PCOMMA = 5'd8;
  localparam logic [4:0] PH_PX     = 5'd9;
  localparam logic [4:0] PH_PY     = 5'd10;
  localparam logic [4:0] PH_RAD    = 5'd11;
  localparam logic [4:0] PH_FLAG   = 5'd14;
  localparam logic [4:0] PH_ASPECT = 5'd15;
  localparam logic [4:0] PH_DONE   = 5'd16;

  localparam logic [4:0] ERR_NONE        = 5'd0;
  localparam logic [4:0] ERR_DUP_CUTOFF  = 5'd1;
  localparam logic [4:0] ERR_COMMA_DIM   = 5'd2;
  localparam logic [4:0] ERR_DIM         = 5'd3;
  localparam logic [4:0] ERR_CLOSE_BOX   = 5'd7;
  localparam logic [4:0] ERR_DUP_POINT   = 5'd8;
  localparam logic [4:0] ERR_CLOSE_ASP   = 5'd14;
  localparam logic [4:0] ERR_CLOSE_FLAG  = 5'd15;
  localparam logic [4:0] ERR_UNEXPECTED  = 5'd16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;

  localparam int DivSteps = 32;

  typedef struct packed {
    logic feed;
    logic feed_zero;
    logic div_load;
    logic div_step;
    logic div_last;
    logic clamp;
    logic clear;
  } glsp_cmd_t;

  typedef struct packed {
    logic need_div;
  } glsp_stat_t;

endpackage

// ===== rtl/core/glsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// glsp_ctrl
// Sequencer: character intake, end of string, divide, clamp, result hold.
// ----------------------------------------------------------------------------
`include "geo_location_spec_parser_assert.svh"

module glsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_char,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output glsp_pkg::glsp_cmd_t cmd,
  input  glsp_pkg::glsp_stat_t stat
);
  import glsp_pkg::*;

  typedef enum logic [2:0] {
    S_RUN, S_END, S_PREP, S_DIV, S_CLAMP, S_OUT
  } state_t;

  state_t     state_r;
  logic [4:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_RUN: if (in_valid && in_last_char) state_r <= S_END;
        S_END: state_r <= S_PREP;
        S_PREP: begin
          cnt_r   <= '0;
          state_r <= stat.need_div ? S_DIV : S_CLAMP;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(DivSteps - 1)) state_r <= S_CLAMP;
        end
        S_CLAMP: state_r <= S_OUT;
        S_OUT: if (!out_stall) state_r <= S_RUN;
        default: state_r <= S_RUN;
      endcase
    end
  end

  assign in_stall  = (state_r != S_RUN);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd           = '0;
    cmd.feed      = (state_r == S_RUN) && in_valid;
    cmd.feed_zero = (state_r == S_END);
    cmd.div_load  = (state_r == S_PREP);
    cmd.div_step  = (state_r == S_DIV);
    cmd.div_last  = (state_r == S_DIV) && (cnt_r == 5'(DivSteps - 1));
    cmd.clamp     = (state_r == S_CLAMP);
    cmd.clear     = (state_r == S_OUT) && !out_stall;
  end

  `GLSP_ASSERT_IMPL(a_out_blocks_in, out_valid, in_stall, "input open while result waits")
  `GLSP_ASSERT_NEXT(a_out_once, out_valid && !out_stall, !out_valid, "result repeated")
  `GLSP_ASSERT_NEXT(a_last_ends, cmd.feed && in_last_char, in_stall && !out_valid,
                    "end of string not sequenced")
  `GLSP_ASSERT_IMPL(a_div_quiet, cmd.div_step, !out_valid && in_stall, "divide overlaps io")

endmodule

// ===== rtl/core/glsp_dp.sv =====
// ----------------------------------------------------------------------------
// glsp_dp
// Parse registers, number accumulator, restoring divider and box clamp.
// ----------------------------------------------------------------------------
module glsp_dp #(
  parameter int COORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_char_code,
  input  glsp_pkg::glsp_cmd_t  cmd,
  output glsp_pkg::glsp_stat_t stat,
  output logic [4:0]           status,
  output logic signed [31:0]   min_x,
  output logic signed [31:0]   max_x,
  output logic signed [31:0]   min_y,
  output logic signed [31:0]   max_y,
  output logic signed [31:0]   center_x,
  output logic signed [31:0]   center_y,
  output logic [31:0]          radius_out,
  output logic [31:0]          aspect_out,
  output logic                 rank_on_distance,
  output logic                 prune_on_distance
);
  import glsp_pkg::*;

  localparam int SH = 32 - COORD_BITS;
  localparam logic signed [31:0] FULL_MIN = 32'(-(longint'(1) << (COORD_BITS - 1)));
  localparam logic signed [31:0] FULL_MAX = 32'((longint'(1) << (COORD_BITS - 1)) - 1);

  logic [4:0]         ph_r, ph_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic               neg_r, neg_nxt, fresh_r, fresh_nxt;
  logic               scut_r, scut_nxt, spt_r, spt_nxt;
  logic [4:0]         err_r, err_nxt;
  logic signed [31:0] b0_r, b1_r, b2_r, b3_r, b0_nxt, b1_nxt, b2_nxt, b3_nxt;
  logic [31:0]        px_r, py_r, rad_r, asp_r, px_nxt, py_nxt, rad_nxt, asp_nxt;
  logic               rank_r, prune_r;
  logic [32:0]        rem_r;
  logic [31:0]        q_r, dx_r;
  logic [32:0]        rem_sh, rem_sub;
  logic               q_bit;

  logic [7:0]  ch;
  logic [31:0] val;
  logic        is_digit;

  always_comb begin
    ch       = cmd.feed_zero ? CH_NUL : in_char_code;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    val      = neg_r ? (32'd0 - acc_r) : acc_r;
    ph_nxt   = ph_r;   acc_nxt = acc_r;  neg_nxt = neg_r; fresh_nxt = fresh_r;
    scut_nxt = scut_r; spt_nxt = spt_r;  err_nxt = err_r;
    b0_nxt = b0_r; b1_nxt = b1_r; b2_nxt = b2_r; b3_nxt = b3_r;
    px_nxt = px_r; py_nxt = py_r; rad_nxt = rad_r; asp_nxt = asp_r;
    priority if (ph_r == PH_DONE) begin
    end else if (ph_r == PH_TOP) begin
      priority if (ch == CH_LBRK) begin
        if (scut_r) begin
          err_nxt = ERR_DUP_CUTOFF; ph_nxt = PH_DONE;
        end else begin
          scut_nxt = 1'b1; ph_nxt = PH_CDIM;
        end
      end else if (ch == CH_LPAR) begin
        if (spt_r) begin
          err_nxt = ERR_DUP_POINT; ph_nxt = PH_DONE;
        end else begin
          spt_nxt = 1'b1; ph_nxt = PH_PDIM;
        end
      end else if (ch == CH_SPACE) begin
      end else if (ch == CH_NUL) begin
        ph_nxt = PH_DONE;
      end else begin
        err_nxt = ERR_UNEXPECTED; ph_nxt = PH_DONE;
      end
    end else if (ph_r == PH_CDIM || ph_r == PH_PDIM) begin
      if (ch == CH_TWO) ph_nxt = ph_r + 5'd1;
      else begin
        err_nxt = ERR_DIM; ph_nxt = PH_DONE;
      end
    end else if (ph_r == PH_CCOMMA || ph_r == PH_PCOMMA) begin
      if (ch == CH_COMMA) ph_nxt = ph_r + 5'd1;
      else begin
        err_nxt = ERR_COMMA_DIM; ph_nxt = PH_DONE;
      end
    end else if (fresh_r && ch == CH_MINUS) begin
      neg_nxt = 1'b1; fresh_nxt = 1'b0;
    end else if (is_digit) begin
      fresh_nxt = 1'b0;
      acc_nxt   = (acc_r << 3) + (acc_r << 1) + {24'd0, ch - CH_ZERO};
    end else begin
      unique case (ph_r)
        PH_MINX:   b0_nxt  = val;
        PH_MINY:   b2_nxt  = val;
        PH_MAXX:   b1_nxt  = val;
        PH_MAXY:   b3_nxt  = val;
        PH_PX:     px_nxt  = val;
        PH_PY:     py_nxt  = val;
        PH_RAD:    rad_nxt = val;
        PH_ASPECT: asp_nxt = val;
        default: ;
      endcase
      acc_nxt = '0; neg_nxt = 1'b0; fresh_nxt = 1'b1;
      priority if (ph_r == PH_MAXY) begin
        if (ch == CH_RBRK) ph_nxt = PH_TOP;
        else begin
          err_nxt = ERR_CLOSE_BOX; ph_nxt = PH_DONE;
        end
      end else if (ph_r == PH_FLAG) begin
        if (ch == CH_COMMA) ph_nxt = PH_ASPECT;
        else if (ch == CH_RPAR) ph_nxt = PH_TOP;
        else begin
          err_nxt = ERR_CLOSE_FLAG; ph_nxt = PH_DONE;
        end
      end else if (ph_r == PH_ASPECT) begin
        if (ch == CH_RPAR) ph_nxt = PH_TOP;
        else begin
          err_nxt = ERR_CLOSE_ASP; ph_nxt = PH_DONE;
        end
      end else begin
        if (ch == CH_COMMA) ph_nxt = ph_r + 5'd1;
        else begin
          err_nxt = (ph_r < PH_PDIM) ? ph_r + 5'd1 : ph_r;
          ph_nxt  = PH_DONE;
        end
      end
    end
  end

  assign stat.need_div = (err_r == ERR_NONE) && spt_r && (asp_r != 32'd0) && (rad_r < asp_r);

  always_comb begin
    rem_sh  = {rem_r[31:0], 1'b1};
    rem_sub = rem_sh - {1'b0, asp_r};
    q_bit   = (rem_sh >= {1'b0, asp_r});
  end

  function automatic logic signed [31:0] wrap_cb(input logic [31:0] v);
    return $signed(v << SH) >>> SH;
  endfunction

  logic signed [33:0] ex_lo, ex_hi, ey_lo, ey_hi;
  logic signed [31:0] w_xl, w_xh, w_yl, w_yh;
  logic signed [31:0] c0, c1, c2, c3;
  logic               do_clamp;

  always_comb begin
    ex_lo = 34'(signed'(px_r)) - $signed({2'b00, dx_r});
    ex_hi = 34'(signed'(px_r)) + $signed({2'b00, dx_r});
    ey_lo = 34'(signed'(py_r)) - $signed({2'b00, rad_r});
    ey_hi = 34'(signed'(py_r)) + $signed({2'b00, rad_r});
    w_xl  = wrap_cb(px_r - dx_r);
    w_xh  = wrap_cb(px_r + dx_r);
    w_yl  = wrap_cb(py_r - rad_r);
    w_yh  = wrap_cb(py_r + rad_r);
    do_clamp = (err_r == ERR_NONE) && spt_r;
    c0 = b0_r; c1 = b1_r; c2 = b2_r; c3 = b3_r;
    if (do_clamp) begin
      if (w_xl > b0_r && ex_lo > 34'(b0_r)) c0 = w_xl;
      if (w_xh < b1_r && ex_hi < 34'(b1_r)) c1 = w_xh;
      if (w_yl > b2_r && ey_lo > 34'(b2_r)) c2 = w_yl;
      if (w_yh < b3_r && ey_hi < 34'(b3_r)) c3 = w_yh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      ph_r <= PH_TOP; acc_r <= '0; neg_r <= 1'b0; fresh_r <= 1'b1;
      scut_r <= 1'b0; spt_r <= 1'b0; err_r <= ERR_NONE;
      b0_r <= FULL_MIN; b1_r <= FULL_MAX; b2_r <= FULL_MIN; b3_r <= FULL_MAX;
      px_r <= '0; py_r <= '0; rad_r <= '1; asp_r <= '0;
      rank_r <= 1'b0; prune_r <= 1'b0;
    end else if (cmd.feed || cmd.feed_zero) begin
      ph_r <= ph_nxt; acc_r <= acc_nxt; neg_r <= neg_nxt; fresh_r <= fresh_nxt;
      scut_r <= scut_nxt; spt_r <= spt_nxt; err_r <= err_nxt;
      b0_r <= b0_nxt; b1_r <= b1_nxt; b2_r <= b2_nxt; b3_r <= b3_nxt;
      px_r <= px_nxt; py_r <= py_nxt; rad_r <= rad_nxt; asp_r <= asp_nxt;
    end else if (cmd.clamp) begin
      b0_r <= c0; b1_r <= c1; b2_r <= c2; b3_r <= c3;
      rank_r  <= do_clamp;
      prune_r <= (err_r == ERR_NONE) &&
                 (c0 != FULL_MIN || c1 != FULL_MAX || c2 != FULL_MIN || c3 != FULL_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= {1'b0, rad_r};
      q_r   <= '0;
      dx_r  <= (asp_r == 32'd0) ? rad_r : 32'hffff_ffff;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_sub : rem_sh;
      q_r   <= {q_r[30:0], q_bit};
      if (cmd.div_last) dx_r <= {q_r[30:0], q_bit};
    end
  end

  assign status            = err_r;
  assign min_x             = b0_r;
  assign max_x             = b1_r;
  assign min_y             = b2_r;
  assign max_y             = b3_r;
  assign center_x          = px_r;
  assign center_y          = py_r;
  assign radius_out        = rad_r;
  assign aspect_out        = asp_r;
  assign rank_on_distance  = rank_r;
  assign prune_on_distance = prune_r;

endmodule

// ===== rtl/core/geo_location_spec_parser.sv =====
// ----------------------------------------------------------------------------
// geo_location_spec_parser
// Character-serial location spec parser with bounding box output.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one character (in_char_code) per
// item; in_last_char marks the final character of a spec. Characters are
// taken one per cycle while the parser is in its intake phase.
// Output channel: out_valid / out_stall carry one result per spec: status,
// the clamped box, the point, radius, aspect and the rank and prune flags.
// After the last character the parser closes the spec, prepares the x
// half-width, runs a restoring divide when an x aspect needs one (one
// quotient bit per cycle) and clamps the box; out_valid is then raised.
// The result is held while out_stall is high and input stays stalled until
// it is taken; then the parse state clears for the next spec.
// Reset (rst_n low, synchronous) returns the parser to its top-level state
// with the full box range and no result pending.
// ----------------------------------------------------------------------------
module geo_location_spec_parser #(
  parameter int COORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_status,
  output logic signed [31:0] out_min_x,
  output logic signed [31:0] out_max_x,
  output logic signed [31:0] out_min_y,
  output logic signed [31:0] out_max_y,
  output logic signed [31:0] out_center_x,
  output logic signed [31:0] out_center_y,
  output logic [31:0]        out_radius_out,
  output logic [31:0]        out_aspect_out,
  output logic               out_rank_on_distance,
  output logic               out_prune_on_distance
);
  import glsp_pkg::*;

  glsp_cmd_t  cmd;
  glsp_stat_t stat;

  glsp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_char(in_last_char),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .stat        (stat)
  );

  glsp_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_char_code     (in_char_code),
    .cmd              (cmd),
    .stat             (stat),
    .status           (out_status),
    .min_x            (out_min_x),
    .max_x            (out_max_x),
    .min_y            (out_min_y),
    .max_y            (out_max_y),
    .center_x         (out_center_x),
    .center_y         (out_center_y),
    .radius_out       (out_radius_out),
    .aspect_out       (out_aspect_out),
    .rank_on_distance (out_rank_on_distance),
    .prune_on_distance(out_prune_on_distance)
  );

endmodule
